// ===== design/kvt_pkg.sv =====
// shared types and constants for the key-value table
package kvt_pkg;

  localparam int KEY_W  = 8;
  localparam int DATA_W = 32;
  localparam int USED_W = 5;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

// ===== design/kvt_if.sv =====
// request and response channel interfaces of the key-value table
interface kvt_req_if import kvt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] found_value;
  logic [USED_W-1:0] entries_used;

  modport source (output valid, output status, output found_value, output entries_used,
                  input ready);
  modport sink   (input valid, input status, input found_value, input entries_used,
                  output ready);
endinterface

// ===== design/key_value_table_linear.sv =====
// top level of the linearly searched key-value table
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   func, key, value
//   out_ch   out  valid/ready   status, found_value, entries_used
//
// lookup, insert and remove scan one held entry per cycle through the single
// read port of the entry memory; a hit on remove then moves the last entry into its slot
// full table, empty table and unused codes skip the scan
// reset clears the state, entry count, pending flag and output valid; the memory is not cleared
// a result waits in the output register while the next transaction is taken
module key_value_table_linear import kvt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kvt_req_if.sink   in_ch,
  kvt_rsp_if.source out_ch
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int ENT_W = KEY_W + VALUE_BITS;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  kvt_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  kvt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/kvt_ram.sv =====
// single-port-write, single-port-read entry memory with registered read data
module kvt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/kvt_ctrl.sv =====
// search, update and response sequencer of the key-value table
module kvt_ctrl import kvt_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  localparam int AW    = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int ENT_W = KEY_W + VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  kvt_req_if.sink          in_ch,
  kvt_rsp_if.source        out_ch,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [ENT_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [ENT_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOVE, S_DONE} state_t;

  state_t                state_r, state_nxt;
  func_t                 op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         cmp_r, cmp_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [DATA_W-1:0]     res_fv_r, res_fv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [DATA_W-1:0]     out_fv_r, out_fv_nxt;
  logic [USED_W-1:0]     out_used_r, out_used_nxt;

  logic [KEY_W-1:0]             rd_key;
  logic [VALUE_BITS-1:0]        rd_val;
  logic                         hit;
  logic                         full;
  logic [CNT_W-1:0]             count_m1;
  logic [VALUE_BITS+DATA_W-1:0] in_ext;
  logic [VALUE_BITS+DATA_W-1:0] fv_ext;
  logic [CNT_W+USED_W-1:0]      used_ext;

  assign rd_key   = ram_rdata[VALUE_BITS +: KEY_W];
  assign rd_val   = ram_rdata[VALUE_BITS-1:0];
  assign hit      = pend_r && (rd_key == key_r);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign count_m1 = count_r - CNT_W'(1);
  assign in_ext   = {{VALUE_BITS{1'b0}}, in_ch.value};
  assign fv_ext   = {{DATA_W{1'b0}}, rd_val};
  assign used_ext = {{USED_W{1'b0}}, count_r};

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.found_value  = out_fv_r;
  assign out_ch.entries_used = out_used_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    cmp_nxt        = cmp_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_fv_nxt     = res_fv_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_fv_nxt     = out_fv_r;
    out_used_nxt   = out_used_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = {key_r, val_r};
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = func_t'(in_ch.func);
          key_nxt        = in_ch.key;
          val_nxt        = in_ext[VALUE_BITS-1:0];
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          res_fv_nxt     = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          unique case (func_t'(in_ch.func))
            FN_LOOKUP, FN_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_MISSING;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {in_ch.key, in_ext[VALUE_BITS-1:0]};
                count_nxt = count_r + CNT_W'(1);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
          unique case (op_r)
            FN_LOOKUP: begin
              res_fv_nxt = fv_ext[DATA_W-1:0];
            end
            FN_INSERT: begin
              res_status_nxt = ST_PRESENT;
            end
            default: begin
              slot_nxt  = cmp_r;
              ram_re    = 1'b1;
              ram_raddr = count_m1[AW-1:0];
              state_nxt = S_MOVE;
            end
          endcase
        end else if (idx_r == count_r) begin
          state_nxt = S_DONE;
          if (op_r == FN_INSERT) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            res_status_nxt = ST_MISSING;
          end
        end else begin
          ram_re   = 1'b1;
          cmp_nxt  = idx_r[AW-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = ram_rdata;
        count_nxt = count_m1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fv_nxt     = res_fv_r;
          out_used_nxt   = used_ext[USED_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    cmp_r        <= cmp_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_fv_r     <= res_fv_nxt;
    out_status_r <= out_status_nxt;
    out_fv_r     <= out_fv_nxt;
    out_used_r   <= out_used_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> count_r != $past(count_r))
    else $error("entry write without count change");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= count_r)
    else $error("scan index past entry count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_status_r == ST_FULL) |-> full)
    else $error("table full reported below capacity");

endmodule
